// ===== hdl/mcc_pkg.sv =====
// Package for the MIDI control-change to CV converter.
// Holds shared constants, the configuration struct and the target voltage table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mcc_pkg;

   localparam int CV_W          = 16;
   localparam int CC_W          = 7;
   localparam int COEFF_W       = 16;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 16;
   localparam int TABLE_DEPTH   = 128;

   localparam logic [CV_W-1:0] CV_FULL_SCALE = 16'd40960;
   localparam logic [CV_W-1:0] CV_ONE_VOLT   = 16'd4096;
   localparam int              CC_MAX        = 127;

   localparam logic [3:0] STATUS_CONTROL_CHANGE = 4'hB;
   localparam logic [1:0] MIN_CC_BYTES          = 2'd3;

   localparam logic                CMD_MESSAGE = 1'b0;
   localparam logic                CMD_TICK    = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_SMOOTH_ENABLE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMOOTH_COEFF  = 1'd1;

   localparam logic               SMOOTH_ENABLE_RESET = 1'b1;
   localparam logic [COEFF_W-1:0] SMOOTH_COEFF_RESET  = 16'd45;

   typedef struct packed {
      logic               enable;
      logic [COEFF_W-1:0] coeff;
   } slew_cfg_type;

   typedef logic [CV_W-1:0] cv_table_type [0:TABLE_DEPTH-1];

   // Target voltage for each 7-bit value, rounded to nearest; built at elaboration.
   function automatic cv_table_type build_cv_table();
      cv_table_type t;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         t[i] = CV_W'((i * 40960 + 63) / 127);
      end
      return t;
   endfunction

   localparam cv_table_type CV_TABLE = build_cv_table();

endpackage
`default_nettype wire

// ===== hdl/midi_cc_to_cv_smoother.sv =====
// An accepted tick request passes through the tick stage, then the result register.
// Throughput: one request per cycle; the input stalls only while a tick waits in the stage
// behind a result that is not being taken. A tick accepted right behind one to the same
// controller is served from the write bypass of the voltage store.
// Reset: synchronous; all stored values and voltages read as zero, smoothing on,
// coefficient 45. Depends on mcc_pkg, mcc_store and mcc_slew.
`timescale 1ns / 1ps
`default_nettype none
module midi_cc_to_cv_smoother #(
   parameter int NUM_CONTROLLERS = 128
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_command,
   input  wire logic [3:0]                        req_status_nibble,
   input  wire logic [1:0]                        req_message_bytes,
   input  wire logic [mcc_pkg::CC_W-1:0]          req_controller_number,
   input  wire logic [mcc_pkg::CC_W-1:0]          req_controller_value,
   input  wire logic [mcc_pkg::CC_W-1:0]          req_tick_channel,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [mcc_pkg::CC_W-1:0]          rsp_out_channel,
   output logic      [mcc_pkg::CV_W-1:0]          rsp_cv_value,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [mcc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [mcc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import mcc_pkg::*;

   localparam int ADDR_W = (NUM_CONTROLLERS > 1) ? $clog2(NUM_CONTROLLERS) : 1;

   slew_cfg_type    cfg_ff;
   logic            s1_valid_ff;
   logic [CC_W-1:0] s1_channel_ff;
   logic            rsp_valid_ff;
   logic [CC_W-1:0] rsp_channel_ff;
   logic [CV_W-1:0] rsp_cv_ff;

   logic            req_fire;
   logic            msg_store;
   logic            tick_take;
   logic            s1_go;
   logic            cv_wr;
   logic [CC_W-1:0] stored_value;
   logic [CV_W-1:0] cur_cv;
   logic [CV_W-1:0] target_cv;
   logic [CV_W-1:0] next_cv;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable <= SMOOTH_ENABLE_RESET;
         cfg_ff.coeff  <= SMOOTH_COEFF_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SMOOTH_ENABLE: cfg_ff.enable <= csr_wdata[0];
            CSR_SMOOTH_COEFF:  cfg_ff.coeff  <= csr_wdata[COEFF_W-1:0];
            default:           cfg_ff        <= cfg_ff;
         endcase
      end
   end

   // The tick stage moves on whenever the result register is free or being emptied.
   assign s1_go     = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || s1_go;
   assign req_fire  = req_valid && req_ready;

   assign msg_store = req_fire && (req_command == CMD_MESSAGE)
                      && (req_status_nibble == STATUS_CONTROL_CHANGE)
                      && (req_message_bytes >= MIN_CC_BYTES)
                      && ({1'b0, req_controller_number} < 8'(NUM_CONTROLLERS));
   assign tick_take = req_fire && (req_command == CMD_TICK)
                      && ({1'b0, req_tick_channel} < 8'(NUM_CONTROLLERS));
   assign cv_wr     = s1_valid_ff && s1_go;

   mcc_store #(
      .DEPTH  (NUM_CONTROLLERS),
      .WIDTH  (CC_W),
      .ADDR_W (ADDR_W)
   ) u_value_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (msg_store),
      .wr_addr (req_controller_number[ADDR_W-1:0]),
      .wr_data (req_controller_value),
      .rd_en   (tick_take),
      .rd_addr (req_tick_channel[ADDR_W-1:0]),
      .rd_data (stored_value)
   );

   mcc_store #(
      .DEPTH  (NUM_CONTROLLERS),
      .WIDTH  (CV_W),
      .ADDR_W (ADDR_W)
   ) u_cv_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cv_wr),
      .wr_addr (s1_channel_ff[ADDR_W-1:0]),
      .wr_data (next_cv),
      .rd_en   (tick_take),
      .rd_addr (req_tick_channel[ADDR_W-1:0]),
      .rd_data (cur_cv)
   );

   assign target_cv = CV_TABLE[stored_value];

   mcc_slew u_slew (
      .cfg     (cfg_ff),
      .cur     (cur_cv),
      .target  (target_cv),
      .next_cv (next_cv)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= tick_take;
         end
         if (s1_go) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tick_take) begin
         s1_channel_ff <= req_tick_channel;
      end
      if (cv_wr) begin
         rsp_channel_ff <= s1_channel_ff;
         rsp_cv_ff      <= next_cv;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_channel_ff;
   assign rsp_cv_value    = rsp_cv_ff;

endmodule
`default_nettype wire

// ===== hdl/mcc_store.sv =====
// Per-controller storage with registered read, per-entry valid bits and write bypass.
// Entries never written read as zero. Depends on nothing outside itself.
`timescale 1ns / 1ps
`default_nettype none
module mcc_store #(
   parameter int DEPTH  = 128,
   parameter int WIDTH  = 16,
   parameter int ADDR_W = 7
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] data_ff;
   logic             hit_ff;
   logic             byp_ff;
   logic [WIDTH-1:0] byp_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_ff     <= mem[rd_addr];
         byp_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
         byp_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            hit_ff <= valid_ff[rd_addr];
            // A write to the same entry on the same edge is newer than the array.
            byp_ff <= wr_en && (wr_addr == rd_addr);
         end
      end
   end

   always_comb begin
      if (byp_ff) begin
         rd_data = byp_data_ff;
      end else if (hit_ff) begin
         rd_data = data_ff;
      end else begin
         rd_data = '0;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/mcc_slew.sv =====
// One-pole slew step: moves the current voltage toward the target.
// Uses mcc_pkg for widths and the configuration struct.
`timescale 1ns / 1ps
`default_nettype none
module mcc_slew (
   input  wire mcc_pkg::slew_cfg_type           cfg,
   input  wire logic [mcc_pkg::CV_W-1:0]        cur,
   input  wire logic [mcc_pkg::CV_W-1:0]        target,
   output logic      [mcc_pkg::CV_W-1:0]        next_cv
);
   import mcc_pkg::*;

   logic            rising;
   logic [CV_W-1:0] mag;
   logic [27:0]     prod;
   logic [28:0]     rounded;
   logic [12:0]     step_raw;
   logic [CV_W-1:0] step;

   always_comb begin
      rising   = (target >= cur);
      mag      = rising ? (target - cur) : (cur - target);
      prod     = 28'(mag[11:0]) * 28'(cfg.coeff);
      rounded  = {1'b0, prod} + 29'd32768;
      step_raw = rounded[28:16];
      step     = CV_W'(step_raw);
      // A non-zero coefficient always makes progress, so the output converges.
      if ((step_raw == '0) && (mag != '0) && (cfg.coeff != '0)) begin
         step = CV_W'(1);
      end
      if (step > mag) begin
         step = mag;
      end
      if (!cfg.enable || (mag >= CV_ONE_VOLT)) begin
         next_cv = target;
      end else if (rising) begin
         next_cv = cur + step;
      end else begin
         next_cv = cur - step;
      end
   end

endmodule
`default_nettype wire

// ===== verif/midi_cc_to_cv_smoother_test.sv =====
// Self-checking testbench for midi_cc_to_cv_smoother: a directed table of requests,
// then random phases under several slew settings, each result checked against a predictor.
// Depends on mcc_pkg and the midi_cc_to_cv_smoother RTL.
`timescale 1ns / 1ps
module midi_cc_to_cv_smoother_test;
   import mcc_pkg::*;

   typedef struct {
      logic             command;
      logic [3:0]       status;
      logic [1:0]       nbytes;
      logic [CC_W-1:0]  ctl;
      logic [CC_W-1:0]  val;
      logic [CC_W-1:0]  ch;
      bit               pinned;
      logic [CV_W-1:0]  pinned_cv;
   } stim_row_type;

   typedef struct {
      logic [CC_W-1:0] channel;
      logic [CV_W-1:0] cv;
   } cv_result_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_command;
   logic [3:0]             req_status_nibble;
   logic [1:0]             req_message_bytes;
   logic [CC_W-1:0]        req_controller_number;
   logic [CC_W-1:0]        req_controller_value;
   logic [CC_W-1:0]        req_tick_channel;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [CC_W-1:0]        rsp_out_channel;
   logic [CV_W-1:0]        rsp_cv_value;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Predicted state of the block.
   logic [CC_W-1:0]    stored_cc [0:TABLE_DEPTH-1];
   logic [CV_W-1:0]    cv_state [0:TABLE_DEPTH-1];
   logic               cfg_enable;
   logic [COEFF_W-1:0] cfg_coeff;

   cv_result_type cv_expected_q [$];
   stim_row_type  directed_rows [$];
   bit         pinned_valid;
   logic [CV_W-1:0] pinned_cv;
   bit         quiet;
   bit         hold_off_pending;
   int         error_count;

   midi_cc_to_cv_smoother uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_command           (req_command),
      .req_status_nibble     (req_status_nibble),
      .req_message_bytes     (req_message_bytes),
      .req_controller_number (req_controller_number),
      .req_controller_value  (req_controller_value),
      .req_tick_channel      (req_tick_channel),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_out_channel       (rsp_out_channel),
      .rsp_cv_value          (rsp_cv_value),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int unsigned cc_target_voltage(input logic [CC_W-1:0] v);
      return (int'(v) * 40960 + 63) / 127;
   endfunction

   // Moves one controller's voltage toward its target and returns the new voltage.
   function automatic logic [CV_W-1:0] advance_voltage(input logic [CC_W-1:0] ch);
      int unsigned target;
      int unsigned now_cv;
      int unsigned mag;
      int unsigned step;
      target = cc_target_voltage(stored_cc[ch]);
      now_cv = 32'(cv_state[ch]);
      mag = (target >= now_cv) ? target - now_cv : now_cv - target;
      if (!cfg_enable || mag >= 4096) begin
         now_cv = target;
      end else begin
         step = (mag * 32'(cfg_coeff) + 32768) >> 16;
         if (step == 0 && mag != 0 && cfg_coeff != '0) step = 1;
         if (step > mag) step = mag;
         now_cv = (target >= now_cv) ? now_cv + step : now_cv - step;
      end
      cv_state[ch] = now_cv[CV_W-1:0];
      return now_cv[CV_W-1:0];
   endfunction

   task automatic report_mismatch(input string what, input int expv, input int actv);
      if (error_count < 10) begin
         $display("ERROR at %0t: %s expected %0d got %0d", $time, what, expv, actv);
      end
      error_count++;
   endtask

   // Results are checked before the request of the same edge is predicted.
   always @(posedge clock) begin : check_results
      cv_result_type due;
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (cv_expected_q.size() == 0) begin
               report_mismatch("unexpected result on channel", -1, int'(rsp_out_channel));
            end else begin
               due = cv_expected_q.pop_front();
               if (rsp_out_channel !== due.channel)
                  report_mismatch("out_channel", int'(due.channel), int'(rsp_out_channel));
               if (rsp_cv_value !== due.cv)
                  report_mismatch("cv_value", int'(due.cv), int'(rsp_cv_value));
            end
         end
         if (req_valid && req_ready === 1'b1) begin
            if (req_command == CMD_TICK) begin
               due.channel = req_tick_channel;
               due.cv = advance_voltage(req_tick_channel);
               if (pinned_valid) due.cv = pinned_cv;
               cv_expected_q.push_back(due);
            end else if (req_status_nibble == STATUS_CONTROL_CHANGE &&
                         req_message_bytes >= MIN_CC_BYTES) begin
               stored_cc[req_controller_number] = req_controller_value;
            end
         end
      end
   end

   // Result side: a random hold-off before each result, and one long one on request.
   initial begin : result_sink
      int gap;
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         gap = quiet ? 0 : int'($urandom_range(0, 19));
         if (hold_off_pending) begin
            gap = 300;
            hold_off_pending = 1'b0;
         end
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         @(negedge clock);
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(input stim_row_type r);
      int gap;
      gap = quiet ? 0 : int'($urandom_range(0, 19));
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_command           <= r.command;
      req_status_nibble     <= r.status;
      req_message_bytes     <= r.nbytes;
      req_controller_number <= r.ctl;
      req_controller_value  <= r.val;
      req_tick_channel      <= r.ch;
      pinned_valid          <= r.pinned;
      pinned_cv             <= r.pinned_cv;
      req_valid             <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic set_slew(input logic enable, input logic [COEFF_W-1:0] coeff);
      write_register(CSR_SMOOTH_ENABLE, {{(CSR_DATA_W-1){1'b0}}, enable});
      write_register(CSR_SMOOTH_COEFF, coeff);
      csr_valid <= 1'b0;
      cfg_enable = enable;
      cfg_coeff = coeff;
   endtask

   // Lowers the request line and waits until every predicted result has been seen.
   task automatic drain;
      req_valid <= 1'b0;
      while (cv_expected_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic add_row(input logic cmd, input logic [3:0] status,
                          input logic [1:0] nbytes, input logic [CC_W-1:0] ctl,
                          input logic [CC_W-1:0] val, input logic [CC_W-1:0] ch,
                          input bit pinned, input logic [CV_W-1:0] cv);
      stim_row_type r;
      r.command = cmd;
      r.status = status;
      r.nbytes = nbytes;
      r.ctl = ctl;
      r.val = val;
      r.ch = ch;
      r.pinned = pinned;
      r.pinned_cv = cv;
      directed_rows.push_back(r);
   endtask

   // Most traffic goes to a few controllers at both ends of the range, so that
   // voltages settle over many ticks and back-to-back ticks hit the same entry.
   function automatic logic [CC_W-1:0] pick_controller;
      logic [CC_W-1:0] c;
      if ($urandom_range(0, 9) == 0) return CC_W'($urandom_range(0, 127));
      c = CC_W'($urandom_range(0, 3));
      if ($urandom_range(0, 1) != 0) c = c | 7'h7C;
      return c;
   endfunction

   task automatic run_random(input int count);
      stim_row_type r;
      int roll;
      int v;
      for (int i = 0; i < count; i++) begin
         quiet = (i % 64) < 10;
         r.command = CMD_MESSAGE;
         r.status = 4'($urandom_range(0, 15));
         r.nbytes = 2'($urandom_range(0, 3));
         r.ctl = CC_W'($urandom_range(0, 127));
         r.val = CC_W'($urandom_range(0, 127));
         r.ch = CC_W'($urandom_range(0, 127));
         r.pinned = 1'b0;
         r.pinned_cv = '0;
         roll = int'($urandom_range(0, 99));
         if (roll < 45) begin
            r.command = CMD_TICK;
            r.ch = pick_controller();
         end else if (roll < 82) begin
            // Well-formed control change, usually a small move so the slew engages.
            r.status = STATUS_CONTROL_CHANGE;
            r.nbytes = MIN_CC_BYTES;
            r.ctl = pick_controller();
            if ($urandom_range(0, 7) != 0) begin
               v = int'(stored_cc[r.ctl]) + int'($urandom_range(0, 28)) - 14;
               if (v < 0) v = 0;
               if (v > CC_MAX) v = CC_MAX;
               r.val = CC_W'(v);
            end
         end
         send_request(r);
      end
      quiet = 1'b0;
   endtask

   // Ticks offered back to back while the result side holds off for a long stretch.
   task automatic run_backpressure;
      stim_row_type r;
      hold_off_pending = 1'b1;
      quiet = 1'b1;
      for (int i = 0; i < 40; i++) begin
         r.command = CMD_TICK;
         r.status = 4'($urandom_range(0, 15));
         r.nbytes = 2'($urandom_range(0, 3));
         r.ctl = CC_W'($urandom_range(0, 127));
         r.val = CC_W'($urandom_range(0, 127));
         r.ch = pick_controller();
         r.pinned = 1'b0;
         r.pinned_cv = '0;
         send_request(r);
      end
      quiet = 1'b0;
   endtask

   initial begin : stimulus
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_MESSAGE;
      req_status_nibble = '0;
      req_message_bytes = '0;
      req_controller_number = '0;
      req_controller_value = '0;
      req_tick_channel = '0;
      csr_valid = 1'b0;
      csr_index = CSR_SMOOTH_ENABLE;
      csr_wdata = '0;
      pinned_valid = 1'b0;
      pinned_cv = '0;
      quiet = 1'b0;
      hold_off_pending = 1'b0;
      error_count = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         stored_cc[i] = '0;
         cv_state[i] = '0;
      end
      cfg_enable = SMOOTH_ENABLE_RESET;
      cfg_coeff = SMOOTH_COEFF_RESET;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, run with the settings left by reset.
      add_row(CMD_TICK,    4'h0, 2'd0, 7'd0,   7'd0,   7'd0,   1'b1, 16'd0);
      add_row(CMD_TICK,    4'hF, 2'd3, 7'd127, 7'd127, 7'd127, 1'b1, 16'd0);
      add_row(CMD_MESSAGE, STATUS_CONTROL_CHANGE, MIN_CC_BYTES, 7'd127, 7'd127, 7'd0,
              1'b0, 16'd0);
      add_row(CMD_TICK,    4'h0, 2'd0, 7'd0,   7'd0,   7'd127, 1'b1, CV_FULL_SCALE);
      add_row(CMD_MESSAGE, 4'hF, 2'd3, 7'd5,   7'd127, 7'd5,   1'b0, 16'd0);
      add_row(CMD_MESSAGE, STATUS_CONTROL_CHANGE, 2'd2, 7'd5, 7'd127, 7'd5, 1'b0, 16'd0);
      add_row(CMD_MESSAGE, STATUS_CONTROL_CHANGE, 2'd0, 7'd5, 7'd127, 7'd5, 1'b0, 16'd0);
      add_row(CMD_MESSAGE, 4'h0, 2'd3, 7'd5,   7'd127, 7'd5,   1'b0, 16'd0);
      add_row(CMD_TICK,    4'h0, 2'd0, 7'd0,   7'd0,   7'd5,   1'b1, 16'd0);
      add_row(CMD_MESSAGE, STATUS_CONTROL_CHANGE, MIN_CC_BYTES, 7'd0, 7'd1, 7'd127,
              1'b0, 16'd0);
      add_row(CMD_TICK,    4'hB, 2'd3, 7'd127, 7'd127, 7'd0,   1'b0, 16'd0);
      add_row(CMD_TICK,    4'h0, 2'd0, 7'd0,   7'd0,   7'd0,   1'b0, 16'd0);
      add_row(CMD_MESSAGE, STATUS_CONTROL_CHANGE, MIN_CC_BYTES, 7'd127, 7'd0, 7'd0,
              1'b0, 16'd0);
      add_row(CMD_TICK,    4'h0, 2'd0, 7'd0,   7'd0,   7'd127, 1'b1, 16'd0);
      add_row(CMD_MESSAGE, STATUS_CONTROL_CHANGE, MIN_CC_BYTES, 7'd64, 7'd12, 7'd0,
              1'b0, 16'd0);
      add_row(CMD_TICK,    4'h0, 2'd0, 7'd0,   7'd0,   7'd64,  1'b0, 16'd0);
      add_row(CMD_TICK,    4'h0, 2'd0, 7'd0,   7'd0,   7'd64,  1'b0, 16'd0);
      add_row(CMD_MESSAGE, STATUS_CONTROL_CHANGE, MIN_CC_BYTES, 7'd64, 7'd13, 7'd0,
              1'b0, 16'd0);
      add_row(CMD_TICK,    4'h0, 2'd0, 7'd0,   7'd0,   7'd64,  1'b0, 16'd0);
      add_row(CMD_MESSAGE, STATUS_CONTROL_CHANGE, 2'd1, 7'd0, 7'd127, 7'd0, 1'b0, 16'd0);
      add_row(CMD_TICK,    4'h0, 2'd0, 7'd0,   7'd0,   7'd0,   1'b0, 16'd0);
      add_row(CMD_MESSAGE, STATUS_CONTROL_CHANGE, MIN_CC_BYTES, 7'd42, 7'd85, 7'd42,
              1'b0, 16'd0);
      add_row(CMD_TICK,    4'h0, 2'd0, 7'd0,   7'd0,   7'd42,  1'b0, 16'd0);
      foreach (directed_rows[i]) send_request(directed_rows[i]);
      drain();

      // Random phases under different slew settings.
      set_slew(1'b1, SMOOTH_COEFF_RESET);
      run_random(60);
      run_backpressure();
      run_random(40);
      drain();
      set_slew(1'b1, 16'd0);
      run_random(70);
      drain();
      set_slew(1'b1, 16'hFFFF);
      run_random(70);
      drain();
      set_slew(1'b0, COEFF_W'($urandom_range(0, 65535)));
      run_random(70);
      drain();
      set_slew(1'b1, 16'd1);
      run_random(60);
      drain();
      set_slew(1'b1, COEFF_W'($urandom_range(1, 65534)));
      run_random(70);
      drain();

      repeat (10) @(negedge clock);
      if (cv_expected_q.size() != 0)
         report_mismatch("results still outstanding", 0, cv_expected_q.size());
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin : watchdog
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
